@@ sv/stochastic_wang_tile_placer_defines.svh @@
// Assertion macros shared by the Wang tile placer RTL.
`ifndef STOCHASTIC_WANG_TILE_PLACER_DEFINES_SVH
`define STOCHASTIC_WANG_TILE_PLACER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SWTP_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swtp assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define SWTP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swtp assertion failed");

`endif

@@ sv/swtp_pkg.sv @@
// Types, codes and constants of the Wang tile placer.
package swtp_pkg;

  localparam int MAX_TILES_DEF  = 64;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int LABEL_BITS_DEF = 8;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_PLACE   = 2'd2;

  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_STUCK    = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;

  localparam logic [7:0] CFG_SEED   = 8'd0;
  localparam logic [7:0] CFG_WIDTH  = 8'd1;
  localparam logic [7:0] CFG_HEIGHT = 8'd2;
  localparam logic [7:0] CFG_TILES  = 8'd3;

  localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;
  localparam int SM_SHIFT0 = 30;
  localparam int SM_SHIFT1 = 27;
  localparam int SM_SHIFT2 = 31;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] entry_index;
    logic [7:0] in_south;
    logic [7:0] in_north;
    logic [7:0] in_west;
    logic [7:0] in_east;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  cell_x;
    logic [15:0] cell_y;
    logic [5:0]  chosen_entry;
    logic [7:0]  out_south;
    logic [7:0]  out_north;
    logic [7:0]  out_west;
    logic [7:0]  out_east;
    logic        last_cell;
  } result_t;

  typedef enum logic [1:0] {K_LOAD, K_RESTART, K_PLACE} kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] index;
    logic [7:0] south;
    logic [7:0] north;
    logic [7:0] west;
    logic [7:0] east;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PREP, S_SCAN1, S_DRAW, S_MUL1, S_MIX1,
    S_MUL2, S_MIX2, S_MOD, S_SCAN2, S_FIN
  } bstate_t;

endpackage

@@ sv/stochastic_wang_tile_placer.sv @@
// Top level of the Wang tile placer: configuration registers, front and back end.
//
// Requests enter on cmd when start is high and busy is low; busy rises only
// when the two-entry request queue is full. Load and restart requests give
// no result. Each place request gives one result, shown on result for a
// single cycle with done high; the receiver cannot stall and every result
// must be taken in that cycle.
// Configuration: cfg_valid with cfg_index and cfg_data writes register
// cfg_index (0 seed, 1 grid width, 2 grid height, 3 tiles in use); cfg_ready
// is always high. Write only while no request is pending.
// Load and restart requests are handled in the dispatch state of the back end.
// A place request that finds the grid complete or the block stuck answers
// from dispatch. A full placement makes two scans of the atlas memory at one
// entry per cycle, a 64-bit splitmix draw on a shared 32x32 multiplier and a
// bit-serial remainder. Requests are worked one at a time in order.
// Reset clears position, random state, status flags and the queue; atlas
// entries and row edges are undefined until written.
module stochastic_wang_tile_placer #(
  parameter int MAX_TILES  = swtp_pkg::MAX_TILES_DEF,
  parameter int MAX_WIDTH  = swtp_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_BITS = swtp_pkg::LABEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  swtp_pkg::cmd_t     cmd,
  output logic               done,
  output swtp_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0]     seed;
  logic [10:0]     grid_width;
  logic [15:0]     grid_height;
  logic [6:0]      tiles_in_use;
  logic            q_valid;
  logic            q_pop;
  swtp_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= 64'd0;
      grid_width   <= 11'd1;
      grid_height  <= 16'd1;
      tiles_in_use <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swtp_pkg::CFG_SEED:   seed         <= cfg_data;
        swtp_pkg::CFG_WIDTH:  grid_width   <= cfg_data[10:0];
        swtp_pkg::CFG_HEIGHT: grid_height  <= cfg_data[15:0];
        swtp_pkg::CFG_TILES:  tiles_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  swtp_front #(
    .MAX_TILES(MAX_TILES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  swtp_back #(
    .MAX_TILES (MAX_TILES),
    .MAX_WIDTH (MAX_WIDTH),
    .LABEL_BITS(LABEL_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .seed        (seed),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .tiles_in_use(tiles_in_use),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .done        (done),
    .res         (result)
  );

endmodule

@@ sv/swtp_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
module swtp_front #(
  parameter int MAX_TILES = swtp_pkg::MAX_TILES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  swtp_pkg::cmd_t      cmd,
  output logic                q_valid,
  output swtp_pkg::item_t     q_item,
  input  logic                q_pop
);

  swtp_pkg::item_t q [2];
  swtp_pkg::item_t new_item;
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  logic            keep;
  logic            push;

  // Classify the request; drop unused opcodes and out-of-range loads
  always_comb begin
    keep          = 1'b1;
    new_item.kind = swtp_pkg::K_PLACE;
    unique case (cmd.opcode)
      swtp_pkg::OP_LOAD: begin
        new_item.kind = swtp_pkg::K_LOAD;
        keep          = int'(cmd.entry_index) < MAX_TILES;
      end
      swtp_pkg::OP_RESTART: new_item.kind = swtp_pkg::K_RESTART;
      swtp_pkg::OP_PLACE:   new_item.kind = swtp_pkg::K_PLACE;
      default:              keep = 1'b0;
    endcase
    new_item.index = cmd.entry_index;
    new_item.south = cmd.in_south;
    new_item.north = cmd.in_north;
    new_item.west  = cmd.in_west;
    new_item.east  = cmd.in_east;
  end

  assign busy    = (cnt == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (cnt != 2'd0);
  assign q_item  = q[rp];

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // Store queued requests
  always_ff @(posedge clk) begin
    if (push) q[wp] <= new_item;
  end

endmodule

@@ sv/swtp_back.sv @@
// Back end: atlas and row memories, candidate scans, random draw and placement.
`include "stochastic_wang_tile_placer_defines.svh"

module swtp_back #(
  parameter int MAX_TILES  = swtp_pkg::MAX_TILES_DEF,
  parameter int MAX_WIDTH  = swtp_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_BITS = swtp_pkg::LABEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        seed,
  input  logic [10:0]        grid_width,
  input  logic [15:0]        grid_height,
  input  logic [6:0]         tiles_in_use,
  input  logic               q_valid,
  input  swtp_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               done,
  output swtp_pkg::result_t  res
);

  localparam int TI  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW  = $clog2(MAX_TILES + 1);
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW1 = $clog2(MAX_WIDTH + 1);
  localparam int LB  = LABEL_BITS;

  swtp_pkg::bstate_t state, state_next;

  logic [4*LB-1:0] atlas [MAX_TILES];
  logic [LB-1:0]   rowmem [MAX_WIDTH];

  swtp_pkg::item_t cur;
  logic [XW-1:0]   pos_x;
  logic [15:0]     pos_y;
  logic            stuck;
  logic            complete;
  logic [LB-1:0]   left_east;
  logic [63:0]     random_state;
  logic [LB-1:0]   below_q;
  logic [4*LB-1:0] atlas_q;
  logic [CW-1:0]   scan_idx;
  logic            chk_v;
  logic [CW-1:0]   chk_i;
  logic [CW-1:0]   count;
  logic [CW-1:0]   kcnt;
  logic [TI-1:0]   chosen;
  logic [4*LB-1:0] ch_edges;
  logic [63:0]     z;
  logic [63:0]     acc;
  logic [63:0]     prod_q;
  logic [1:0]      mstep;
  logic [63:0]     div;
  logic [CW-1:0]   rem;
  logic [5:0]      bitcnt;

  logic [XW1-1:0]  w_eff;
  logic [15:0]     h_eff;
  logic [CW-1:0]   n_eff;
  logic            wrapx;
  logic [15:0]     py_w;
  logic            cmpl;
  logic            eff_complete;
  logic            hit;
  logic            scan_done;
  logic [63:0]     snew;
  logic [63:0]     mconst;
  logic [31:0]     ma;
  logic [31:0]     mb;
  logic [CW:0]     rtry;
  logic            last;
  logic [XW1-1:0]  px1;
  swtp_pkg::result_t stuck_res;
  swtp_pkg::result_t complete_res;

  // Clamp the configured grid and atlas sizes
  always_comb begin
    if (grid_width == 11'd0) w_eff = XW1'(1);
    else if (int'(grid_width) > MAX_WIDTH) w_eff = XW1'(MAX_WIDTH);
    else w_eff = XW1'(grid_width);
    h_eff = (grid_height == 16'd0) ? 16'd1 : grid_height;
    if (int'(tiles_in_use) > MAX_TILES) n_eff = CW'(MAX_TILES);
    else n_eff = CW'(tiles_in_use);
  end

  // Position wrap and completion check at the start of a placement
  always_comb begin
    wrapx        = XW1'(pos_x) >= w_eff;
    py_w         = wrapx ? 16'(pos_y + 16'd1) : pos_y;
    cmpl         = py_w >= h_eff;
    eff_complete = complete || (!stuck && cmpl);
  end

  // Candidate test on the entry read last cycle
  always_comb begin
    hit = chk_v
      && (pos_x == '0 || atlas_q[2*LB-1:LB] == left_east)
      && (pos_y == 16'd0 || atlas_q[4*LB-1:3*LB] == below_q);
    scan_done = (scan_idx >= n_eff) && !chk_v;
  end

  // Early answers: stuck at the current cell, or grid complete
  always_comb begin
    stuck_res           = '0;
    stuck_res.status    = swtp_pkg::ST_STUCK;
    stuck_res.cell_x    = 10'(pos_x);
    stuck_res.cell_y    = pos_y;
    complete_res        = '0;
    complete_res.status = swtp_pkg::ST_COMPLETE;
  end

  // Operand selection for the shared 32x32 multiplier
  always_comb begin
    snew   = random_state + swtp_pkg::SM_GAMMA;
    mconst = (state == swtp_pkg::S_MUL1) ? swtp_pkg::SM_MUL1 : swtp_pkg::SM_MUL2;
    unique case (mstep)
      2'd0:    begin ma = z[31:0];  mb = mconst[31:0];  end
      2'd1:    begin ma = z[63:32]; mb = mconst[31:0];  end
      2'd2:    begin ma = z[31:0];  mb = mconst[63:32]; end
      default: begin ma = z[31:0];  mb = mconst[31:0];  end
    endcase
    rtry = {rem, div[63]};
    last = (XW1'(pos_x) == w_eff - XW1'(1)) && (pos_y == h_eff - 16'd1);
    px1  = XW1'(pos_x) + XW1'(1);
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) state <= swtp_pkg::S_IDLE;
    else state <= state_next;
  end

  // Next state and queue pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      swtp_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = swtp_pkg::S_DISPATCH;
        end
      end
      swtp_pkg::S_DISPATCH: begin
        if (cur.kind == swtp_pkg::K_PLACE && !eff_complete && !stuck)
          state_next = swtp_pkg::S_PREP;
        else
          state_next = swtp_pkg::S_IDLE;
      end
      swtp_pkg::S_PREP: state_next = swtp_pkg::S_SCAN1;
      swtp_pkg::S_SCAN1: begin
        if (scan_done)
          state_next = (count == '0) ? swtp_pkg::S_IDLE : swtp_pkg::S_DRAW;
      end
      swtp_pkg::S_DRAW: state_next = swtp_pkg::S_MUL1;
      swtp_pkg::S_MUL1: if (mstep == 2'd3) state_next = swtp_pkg::S_MIX1;
      swtp_pkg::S_MIX1: state_next = swtp_pkg::S_MUL2;
      swtp_pkg::S_MUL2: if (mstep == 2'd3) state_next = swtp_pkg::S_MIX2;
      swtp_pkg::S_MIX2: state_next = swtp_pkg::S_MOD;
      swtp_pkg::S_MOD:  if (bitcnt == 6'd63) state_next = swtp_pkg::S_SCAN2;
      swtp_pkg::S_SCAN2: if (scan_done) state_next = swtp_pkg::S_FIN;
      swtp_pkg::S_FIN: state_next = swtp_pkg::S_IDLE;
      default: state_next = swtp_pkg::S_IDLE;
    endcase
  end

  // Atlas memory: load writes, one read per cycle during scans
  always_ff @(posedge clk) begin
    if (state == swtp_pkg::S_DISPATCH && cur.kind == swtp_pkg::K_LOAD)
      atlas[TI'(cur.index)] <= {LB'(cur.south), LB'(cur.north),
                                LB'(cur.west), LB'(cur.east)};
    atlas_q <= atlas[TI'(scan_idx)];
  end

  // Row memory: north edge of the tile placed in each column
  always_ff @(posedge clk) begin
    if (state == swtp_pkg::S_FIN) rowmem[pos_x] <= ch_edges[3*LB-1:2*LB];
    if (state == swtp_pkg::S_PREP) below_q <= rowmem[pos_x];
  end

  // Tiling control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= 16'd0;
      stuck        <= 1'b0;
      complete     <= 1'b0;
      left_east    <= '0;
      random_state <= 64'd0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        swtp_pkg::S_DISPATCH: begin
          if (cur.kind == swtp_pkg::K_RESTART) begin
            pos_x        <= '0;
            pos_y        <= 16'd0;
            random_state <= seed;
            stuck        <= 1'b0;
            complete     <= 1'b0;
            left_east    <= '0;
          end else if (cur.kind == swtp_pkg::K_PLACE) begin
            if (eff_complete || stuck) done <= 1'b1;
            if (!complete && !stuck) begin
              if (wrapx) pos_x <= '0;
              pos_y <= py_w;
              if (cmpl) complete <= 1'b1;
            end
          end
        end
        swtp_pkg::S_SCAN1: begin
          if (scan_done && count == '0) begin
            stuck <= 1'b1;
            done  <= 1'b1;
          end
        end
        swtp_pkg::S_DRAW: random_state <= snew;
        swtp_pkg::S_FIN: begin
          done      <= 1'b1;
          left_east <= ch_edges[LB-1:0];
          if (last) begin
            complete <= 1'b1;
          end else if (px1 >= w_eff) begin
            pos_x <= '0;
            pos_y <= 16'(pos_y + 16'd1);
          end else begin
            pos_x <= XW'(px1);
          end
        end
        default: ;
      endcase
    end
  end

  // Result register: early answers at dispatch or after the first scan, placement at finish
  always_ff @(posedge clk) begin
    unique case (state)
      swtp_pkg::S_DISPATCH: res <= eff_complete ? complete_res : stuck_res;
      swtp_pkg::S_SCAN1:    res <= stuck_res;
      swtp_pkg::S_FIN: begin
        res.status       <= swtp_pkg::ST_PLACED;
        res.cell_x       <= 10'(pos_x);
        res.cell_y       <= pos_y;
        res.chosen_entry <= 6'(chosen);
        res.out_south    <= 8'(ch_edges[4*LB-1:3*LB]);
        res.out_north    <= 8'(ch_edges[3*LB-1:2*LB]);
        res.out_west     <= 8'(ch_edges[2*LB-1:LB]);
        res.out_east     <= 8'(ch_edges[LB-1:0]);
        res.last_cell    <= last;
      end
      default: ;
    endcase
  end

  // Scan, draw and remainder datapath
  always_ff @(posedge clk) begin
    if (state == swtp_pkg::S_IDLE && q_valid) cur <= q_item;
    unique case (state)
      swtp_pkg::S_PREP: begin
        scan_idx <= '0;
        chk_v    <= 1'b0;
        count    <= '0;
      end
      swtp_pkg::S_SCAN1, swtp_pkg::S_SCAN2: begin
        chk_v <= scan_idx < n_eff;
        chk_i <= scan_idx;
        if (scan_idx < n_eff) scan_idx <= scan_idx + CW'(1);
        if (hit) begin
          if (state == swtp_pkg::S_SCAN1) begin
            count <= count + CW'(1);
          end else begin
            if (kcnt == rem) begin
              chosen   <= TI'(chk_i);
              ch_edges <= atlas_q;
            end
            kcnt <= kcnt + CW'(1);
          end
        end
      end
      swtp_pkg::S_DRAW: begin
        z     <= snew ^ (snew >> swtp_pkg::SM_SHIFT0);
        mstep <= 2'd0;
      end
      swtp_pkg::S_MUL1, swtp_pkg::S_MUL2: begin
        prod_q <= ma * mb;
        if (mstep == 2'd1) acc <= prod_q;
        else if (mstep != 2'd0) acc <= acc + {prod_q[31:0], 32'd0};
        mstep <= mstep + 2'd1;
      end
      swtp_pkg::S_MIX1: begin
        z     <= acc ^ (acc >> swtp_pkg::SM_SHIFT1);
        mstep <= 2'd0;
      end
      swtp_pkg::S_MIX2: begin
        div    <= acc ^ (acc >> swtp_pkg::SM_SHIFT2);
        rem    <= '0;
        bitcnt <= 6'd0;
      end
      swtp_pkg::S_MOD: begin
        if (rtry >= {1'b0, count}) rem <= CW'(rtry - {1'b0, count});
        else rem <= rtry[CW-1:0];
        div      <= {div[62:0], 1'b0};
        bitcnt   <= bitcnt + 6'd1;
        scan_idx <= '0;
        chk_v    <= 1'b0;
        kcnt     <= '0;
      end
      default: ;
    endcase
  end

  `SWTP_IMPLIES(a_mod_nonzero, state == swtp_pkg::S_MOD, count != '0)
  `SWTP_IMPLIES(a_pick_range, state == swtp_pkg::S_SCAN2, rem < count)
  `SWTP_NEXT(a_done_single, done, !done)
  `SWTP_IMPLIES(a_placed_not_stuck, done && res.status == swtp_pkg::ST_PLACED, !stuck)

endmodule
